[sv/slm_pkg.sv]
`timescale 1ns / 1ps

package slm_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int FW_W         = 11;
    localparam int FH_W         = 13;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int REP_N        = 4;

    localparam logic [FW_W-1:0] FW_RESET = 11'd64;
    localparam logic [FH_W-1:0] FH_RESET = 13'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    // report kinds, in emission order; value is the bit in the pending mask
    typedef enum logic [1:0] {
        REP_UP_LEFT  = 2'd0,
        REP_UP_HERE  = 2'd1,
        REP_CUR_LEFT = 2'd2,
        REP_CUR_HERE = 2'd3
    } rep_kind_t;

    typedef logic [PIX_W-1:0] pix_t;

    // one line store entry: column pixel of the previous row and the row before it
    typedef struct packed {
        pix_t r1;
        pix_t r2;
    } line_t;

    // one finished column handed to the report unit
    typedef struct packed {
        logic             valid;
        pix_t             top;
        pix_t             mid;
        pix_t             bot;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_ge1;
        logic             row_ge2;
        logic             col_ge1;
        logic             col_ge2;
        logic [REP_N-1:0] reps;
    } slm_col_t;

endpackage

[sv/slm_in_if.sv]
`timescale 1ns / 1ps

interface slm_in_if
    import slm_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

[sv/slm_out_if.sv]
`timescale 1ns / 1ps

interface slm_out_if
    import slm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             is_minimum;
    logic             run_last;
    logic             frame_last;

    modport source (
        output valid, output row, output col, output value,
        output is_minimum, output run_last, output frame_last,
        input ready
    );
    modport sink (
        input valid, input row, input col, input value,
        input is_minimum, input run_last, input frame_last,
        output ready
    );
endinterface

[sv/slm_report.sv]
`timescale 1ns / 1ps

module slm_report
    import slm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  slm_col_t  col_in,
    output logic      col_ready,
    slm_out_if.source reports
);

    // window: row 0 = R-2, 1 = R-1, 2 = R; col 0 = C-2, 1 = C-1, 2 = C
    pix_t             win_reg [3][3];
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             row_ge1_reg;
    logic             row_ge2_reg;
    logic             col_ge1_reg;
    logic             col_ge2_reg;
    logic [REP_N-1:0] reps_reg;

    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    pix_t             out_value_reg;
    logic             out_min_reg;
    logic             out_run_last_reg;
    logic             out_frame_last_reg;

    rep_kind_t        kind;
    logic [REP_N-1:0] reps_rest;
    logic             rep_any;
    logic             out_load;
    logic             take;
    logic [1:0]       ci;
    logic [1:0]       cj;
    pix_t             center;
    logic [ROW_W-1:0] rep_row;
    logic [COL_W-1:0] rep_col;
    logic             rep_frame_last;
    logic             is_min;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;

    always_comb
    begin
        rep_any = (reps_reg != '0);
        if (reps_reg[REP_UP_LEFT])
            kind = REP_UP_LEFT;
        else if (reps_reg[REP_UP_HERE])
            kind = REP_UP_HERE;
        else if (reps_reg[REP_CUR_LEFT])
            kind = REP_CUR_LEFT;
        else
            kind = REP_CUR_HERE;
        reps_rest = reps_reg & ~(REP_N'(1) << kind);
        out_load  = rep_any && (!out_valid_reg || reports.ready);
        col_ready = !rep_any || (out_load && (reps_rest == '0));
        take      = col_in.valid && col_ready;
    end

    always_comb
    begin
        case (kind)
            REP_UP_LEFT:
            begin
                ci             = 2'd1;
                cj             = 2'd1;
                center         = win_reg[1][1];
                rep_row        = row_reg - 1'b1;
                rep_col        = col_reg - 1'b1;
                rep_frame_last = 1'b0;
            end
            REP_UP_HERE:
            begin
                ci             = 2'd1;
                cj             = 2'd2;
                center         = win_reg[1][2];
                rep_row        = row_reg - 1'b1;
                rep_col        = col_reg;
                rep_frame_last = 1'b0;
            end
            REP_CUR_LEFT:
            begin
                ci             = 2'd2;
                cj             = 2'd1;
                center         = win_reg[2][1];
                rep_row        = row_reg;
                rep_col        = col_reg - 1'b1;
                rep_frame_last = 1'b0;
            end
            default:
            begin
                ci             = 2'd2;
                cj             = 2'd2;
                center         = win_reg[2][2];
                rep_row        = row_reg;
                rep_col        = col_reg;
                rep_frame_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        row_ok = {1'b1, row_ge1_reg, row_ge2_reg};
        col_ok = {1'b1, col_ge1_reg, col_ge2_reg};
        is_min = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_ok[i] && col_ok[j] && (2'(i + 1) >= ci) && (2'(j + 1) >= cj)
                    && !((2'(i) == ci) && (2'(j) == cj)) && (center >= win_reg[i][j]))
                    is_min = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reps_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                reps_reg <= col_in.reps;
            else if (out_load)
                reps_reg <= reps_rest;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (reports.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= col_in.top;
            win_reg[1][2] <= col_in.mid;
            win_reg[2][2] <= col_in.bot;
            row_reg       <= col_in.row;
            col_reg       <= col_in.col;
            row_ge1_reg   <= col_in.row_ge1;
            row_ge2_reg   <= col_in.row_ge2;
            col_ge1_reg   <= col_in.col_ge1;
            col_ge2_reg   <= col_in.col_ge2;
        end
        if (out_load)
        begin
            out_row_reg        <= rep_row;
            out_col_reg        <= rep_col;
            out_value_reg      <= center;
            out_min_reg        <= is_min;
            out_run_last_reg   <= (reps_rest == '0);
            out_frame_last_reg <= rep_frame_last;
        end
    end

    assign reports.valid      = out_valid_reg;
    assign reports.row        = out_row_reg;
    assign reports.col        = out_col_reg;
    assign reports.value      = out_value_reg;
    assign reports.is_minimum = out_min_reg;
    assign reports.run_last   = out_run_last_reg;
    assign reports.frame_last = out_frame_last_reg;

endmodule

[sv/strict_local_minimum_3x3.sv]
`timescale 1ns / 1ps

// Strict 3x3 local-minimum detector over a raster-order pixel stream.
// pixels:  valid/ready stream, one pixel per transaction, row by row.
// reports: valid/ready stream of (row, col, value, is_minimum, run_last,
//          frame_last); each pixel is reported once, as soon as its clamped
//          3x3 neighborhood has arrived. run_last marks the last report caused
//          by one input pixel; frame_last marks the final pixel.
// cfg_we/cfg_index/cfg_data: register write (0 = frame_width, 1 = frame_height);
//          any write restarts the frame at row 0, column 0.
// A pixel's reports pass the read stage, window and output registers.
// Throughput: one pixel per cycle while reports is ready and each pixel causes
//          at most one report; reports leave at one per cycle, so a pixel with
//          several (row ends, last row) holds the next pixel until they leave.
// The line store is one MAX_WIDTH x 2-pixel RAM, read at accept and written
// back as the pixel leaves the read stage; a same-column read during that
// write is forwarded.
// Reset: position and handshake state clear, registers go to 64x64; the RAM
// is not cleared (unwritten entries read in the first rows are masked out).
// When reports stalls, the output register holds and the input stalls once
// the report unit and the one-pixel read stage are full.

module strict_local_minimum_3x3
    import slm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                 clk,
    input  logic                 rst_n,
    slm_in_if.sink               pixels,
    slm_out_if.source            reports,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [CW-1:0]    last_col;
    logic [ROW_W-1:0] last_row;

    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;

    line_t            mem [MAX_WIDTH];
    line_t            rd_reg;

    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [CW-1:0]    s1_col_reg;
    pix_t             s1_pix_reg;
    logic [REP_N-1:0] s1_reps_reg;
    logic             s1_fwd_reg;
    line_t            s1_fwd_data_reg;

    logic             in_acc;
    logic             s1_adv;
    logic             col_ready;
    logic             at_last_col;
    logic             at_last_row;
    logic [REP_N-1:0] reps_next;
    line_t            line_cur;
    line_t            wr_line;
    slm_col_t         col_out;

    always_comb
    begin
        if (frame_width_reg == '0)
            last_col = '0;
        else if (WCMP_W'(frame_width_reg) > WCMP_W'(MAX_WIDTH))
            last_col = CW'(MAX_WIDTH - 1);
        else
            last_col = CW'(frame_width_reg - 1'b1);

        if (frame_height_reg == '0)
            last_row = '0;
        else if (frame_height_reg > FH_W'(HEIGHT_LIMIT))
            last_row = ROW_W'(HEIGHT_LIMIT - 1);
        else
            last_row = ROW_W'(frame_height_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= FW_W'(cfg_data);
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_acc       = pixels.valid && pixels.ready;
    assign s1_adv       = s1_valid_reg && col_ready;
    assign pixels.ready = !s1_valid_reg || col_ready;
    assign at_last_col  = (col_reg == last_col);
    assign at_last_row  = (row_reg == last_row);

    always_comb
    begin
        reps_next               = '0;
        reps_next[REP_UP_LEFT]  = (row_reg != '0) && (col_reg != '0);
        reps_next[REP_UP_HERE]  = (row_reg != '0) && at_last_col;
        reps_next[REP_CUR_LEFT] = at_last_row && (col_reg != '0);
        reps_next[REP_CUR_HERE] = at_last_row && at_last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_we)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            if (at_last_col)
            begin
                col_reg <= '0;
                row_reg <= at_last_row ? '0 : row_reg + 1'b1;
            end
            else
                col_reg <= col_reg + 1'b1;
        end
    end

    // read stage
    always_comb
    begin
        line_cur   = s1_fwd_reg ? s1_fwd_data_reg : rd_reg;
        wr_line.r1 = s1_pix_reg;
        wr_line.r2 = line_cur.r1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            mem[s1_col_reg] <= wr_line;
        if (in_acc)
            rd_reg <= mem[col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_pix_reg      <= pixels.pixel;
            s1_reps_reg     <= reps_next;
            s1_fwd_reg      <= s1_adv && (s1_col_reg == col_reg);
            s1_fwd_data_reg <= wr_line;
        end
    end

    always_comb
    begin
        col_out.valid   = s1_valid_reg;
        col_out.top     = line_cur.r2;
        col_out.mid     = line_cur.r1;
        col_out.bot     = s1_pix_reg;
        col_out.row     = s1_row_reg;
        col_out.col     = COL_W'(s1_col_reg);
        col_out.row_ge1 = (s1_row_reg != '0);
        col_out.row_ge2 = (s1_row_reg > ROW_W'(1));
        col_out.col_ge1 = (s1_col_reg != '0);
        col_out.col_ge2 = (s1_col_reg > CW'(1));
        col_out.reps    = s1_reps_reg;
    end

    slm_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_in    (col_out),
        .col_ready (col_ready),
        .reports   (reports)
    );

endmodule

[sv/slm_checker.sv]
`timescale 1ns / 1ps

module slm_checker
    import slm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rep_valid,
    input logic             rep_ready,
    input logic [ROW_W-1:0] rep_row,
    input logic [COL_W-1:0] rep_col,
    input logic [PIX_W-1:0] rep_value,
    input logic             rep_is_minimum,
    input logic             rep_run_last,
    input logic             rep_frame_last
);

    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !rep_valid)
        else $error("report valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=> rep_valid && $stable(rep_row) && $stable(rep_col)
            && $stable(rep_value) && $stable(rep_is_minimum)
            && $stable(rep_run_last) && $stable(rep_frame_last))
        else $error("stalled report transaction changed");

    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && rep_frame_last |-> rep_run_last)
        else $error("frame_last report is not the last of its run");

endmodule

bind strict_local_minimum_3x3 slm_checker u_slm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rep_valid      (reports.valid),
    .rep_ready      (reports.ready),
    .rep_row        (reports.row),
    .rep_col        (reports.col),
    .rep_value      (reports.value),
    .rep_is_minimum (reports.is_minimum),
    .rep_run_last   (reports.run_last),
    .rep_frame_last (reports.frame_last)
);
